// ===== rtl/bsm_pkg.sv =====
// Shared types and constants for the bounding sphere merge block.
// Used by the channel interfaces, the shared units and the top level.
package bsm_pkg;

    localparam int CoordW  = 32;
    localparam int RadW    = 31;
    localparam int OpW     = 34;
    localparam int ProdW   = 2 * OpW;
    localparam int SumW    = 66;
    localparam int IterN   = 34;
    localparam int IterCntW = 6;

    localparam logic [1:0] CASE_IDENT   = 2'd0;
    localparam logic [1:0] CASE_TAKEN   = 2'd1;
    localparam logic [1:0] CASE_KEPT    = 2'd2;
    localparam logic [1:0] CASE_ENLARGE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_CMP,
        ST_SQRT,
        ST_SQRT_WAIT,
        ST_KCALC,
        ST_MV_MUL,
        ST_MV_DIV,
        ST_MV_WAIT,
        ST_FIN,
        ST_OUT
    } bsm_state_t;

    typedef enum logic {
        ITER_SQRT,
        ITER_DIV
    } bsm_iter_mode_t;

    typedef struct packed {
        logic           start;
        bsm_iter_mode_t mode;
    } bsm_iter_ctl_t;

endpackage

// ===== rtl/bsm_sphere_if.sv =====
// Valid/ready channel interfaces for incoming spheres and merged results.
// Depends on bsm_pkg for field widths.
interface bsm_sphere_if;
    import bsm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [CoordW-1:0] in_center_x;
    logic signed [CoordW-1:0] in_center_y;
    logic signed [CoordW-1:0] in_center_z;
    logic        [RadW-1:0]   in_radius;
    modport source (output valid, in_center_x, in_center_y, in_center_z, in_radius,
                    input ready);
    modport sink   (input valid, in_center_x, in_center_y, in_center_z, in_radius,
                    output ready);
endinterface

interface bsm_merged_if;
    import bsm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [CoordW-1:0] out_center_x;
    logic signed [CoordW-1:0] out_center_y;
    logic signed [CoordW-1:0] out_center_z;
    logic        [RadW-1:0]   out_radius;
    logic        [1:0]        merge_case;
    logic                     saturated;
    modport source (output valid, out_center_x, out_center_y, out_center_z, out_radius,
                    merge_case, saturated, input ready);
    modport sink   (input valid, out_center_x, out_center_y, out_center_z, out_radius,
                    merge_case, saturated, output ready);
endinterface

// ===== rtl/bounding_sphere_merge_core.sv =====
// Top level of the running bounding sphere merge block.
// Depends on bsm_pkg, the channel interfaces, bsm_mul and bsm_iter.
//
// Usage: the block keeps one stored sphere (center and radius, Q16.16) that
// reset clears to the empty sphere at the origin. Each transfer on the sphere
// channel offers one sphere; the block answers with exactly one transfer on
// the merged channel carrying the stored sphere after that item, how the item
// was handled (ignored, taken, kept, enlarged) and a saturation flag.
//
// An identical sphere, or one taken into the empty stored sphere, goes
// from the check state straight to the output state. A contained sphere
// is settled after forming the squared distance through the shared
// multiplier. An enlarging merge runs one 34-step square root and three
// 34-step divisions, all sharing one subtract-and-compare unit, plus
// passes through the one shared multiplier.
// The block takes one item at a time; ready is low while an item is in work.
//
// The result sits in an output register. A stalled receiver does not stop
// the block from accepting the next sphere; the block only waits at the end
// of that next item until the previous result has been taken.
// Reset (rst_n, asynchronous, active low) drops valid, returns the sequencer
// to idle with ready high and returns the stored sphere to the empty sentinel.
module bounding_sphere_merge_core (
    input  logic          clk,
    input  logic          rst_n,
    bsm_sphere_if.sink    sphere,
    bsm_merged_if.source  merged
);
    import bsm_pkg::*;

    bsm_state_t state_reg, state_next;

    // Stored sphere and latched incoming sphere, indexed by axis.
    logic signed [CoordW-1:0] acc_c_reg [3];
    logic        [RadW-1:0]   acc_r_reg;
    logic signed [CoordW-1:0] in_c_reg [3];
    logic        [RadW-1:0]   in_r_reg;

    logic [1:0]       axis_reg;
    logic [SumW-1:0]  sum_reg;
    logic [61:0]      diffsq_reg;
    logic [OpW-1:0]   d_reg;
    logic [OpW-1:0]   rtrue_reg;
    logic [OpW-1:0]   k_reg;
    logic [1:0]       case_reg;
    logic             sat_reg;
    logic             neg_reg;

    // Output register.
    logic                     out_valid_reg;
    logic signed [CoordW-1:0] out_cx_reg;
    logic signed [CoordW-1:0] out_cy_reg;
    logic signed [CoordW-1:0] out_cz_reg;
    logic        [RadW-1:0]   out_r_reg;
    logic        [1:0]        out_case_reg;
    logic                     out_sat_reg;

    // Shared unit hookups.
    logic [OpW-1:0]   mul_a;
    logic [OpW-1:0]   mul_b;
    logic [ProdW-1:0] prod;
    bsm_iter_ctl_t    iter_ctl;
    logic             iter_done;
    logic [OpW-1:0]   iter_res;

    logic             accept;
    logic             out_free;
    logic             identical;
    logic             empty_acc;
    logic             contained;
    logic [32:0]      delta;
    logic [32:0]      delta_mag;
    logic [RadW-1:0]  rdiff;
    logic [OpW-1:0]   d_fix;
    logic [34:0]      rsum;
    logic [OpW-1:0]   rtrue;
    logic signed [35:0] moved;
    logic signed [CoordW-1:0] moved_clamped;
    logic             moved_sat;

    bsm_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    bsm_iter u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (iter_ctl),
        .radicand (sum_reg),
        .dividend (prod[66:0]),
        .divisor  (d_reg),
        .done     (iter_done),
        .result   (iter_res)
    );

    assign accept   = sphere.valid && sphere.ready;
    assign out_free = !out_valid_reg || merged.ready;

    // Whole-sphere checks and per-axis arithmetic on the axis the sequencer points at.
    always_comb
    begin
        identical = (in_c_reg[0] == acc_c_reg[0]) && (in_c_reg[1] == acc_c_reg[1]) &&
                    (in_c_reg[2] == acc_c_reg[2]) && (in_r_reg == acc_r_reg);
        empty_acc = (acc_c_reg[0] == '0) && (acc_c_reg[1] == '0) &&
                    (acc_c_reg[2] == '0) && (acc_r_reg == '0);
        contained = (sum_reg <= {4'b0000, diffsq_reg});
        rdiff     = (acc_r_reg > in_r_reg) ? (acc_r_reg - in_r_reg) : (in_r_reg - acc_r_reg);
        delta     = {in_c_reg[axis_reg][31], in_c_reg[axis_reg]}
                  - {acc_c_reg[axis_reg][31], acc_c_reg[axis_reg]};
        delta_mag = delta[32] ? (33'd0 - delta) : delta;
        d_fix     = (iter_res == '0) ? OpW'(1) : iter_res;
        rsum      = {1'b0, d_fix} + 35'(acc_r_reg) + 35'(in_r_reg);
        rtrue     = rsum[34:1];
        // The center moves by the quotient toward the incoming center.
        if (neg_reg)
        begin
            moved = 36'(acc_c_reg[axis_reg]) - $signed({2'b00, iter_res});
        end
        else
        begin
            moved = 36'(acc_c_reg[axis_reg]) + $signed({2'b00, iter_res});
        end
        moved_sat = 1'b0;
        if (moved > 36'sd2147483647)
        begin
            moved_clamped = 32'sh7FFFFFFF;
            moved_sat     = 1'b1;
        end
        else if (moved < -36'sd2147483648)
        begin
            moved_clamped = 32'sh80000000;
            moved_sat     = 1'b1;
        end
        else
        begin
            moved_clamped = moved[31:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (identical || empty_acc)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL:    state_next = ST_SQ_ACC;
            ST_SQ_ACC:
            begin
                state_next = (axis_reg == 2'd3) ? ST_CMP : ST_SQ_MUL;
            end
            ST_CMP:
            begin
                state_next = contained ? ST_OUT : ST_SQRT;
            end
            ST_SQRT:      state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:
            begin
                if (iter_done)
                begin
                    state_next = ST_KCALC;
                end
            end
            ST_KCALC:     state_next = ST_MV_MUL;
            ST_MV_MUL:    state_next = ST_MV_DIV;
            ST_MV_DIV:    state_next = ST_MV_WAIT;
            ST_MV_WAIT:
            begin
                if (iter_done)
                begin
                    state_next = (axis_reg == 2'd2) ? ST_FIN : ST_MV_MUL;
                end
            end
            ST_FIN:       state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        sphere.ready   = 1'b0;
        mul_a          = {1'b0, delta_mag};
        mul_b          = {1'b0, delta_mag};
        iter_ctl.start = 1'b0;
        iter_ctl.mode  = ITER_SQRT;
        unique case (state_reg)
            ST_IDLE:
            begin
                sphere.ready = 1'b1;
            end
            ST_SQ_MUL:
            begin
                if (axis_reg == 2'd3)
                begin
                    mul_a = OpW'(rdiff);
                    mul_b = OpW'(rdiff);
                end
            end
            ST_SQRT:
            begin
                iter_ctl.start = 1'b1;
            end
            ST_MV_MUL:
            begin
                mul_b = k_reg;
            end
            ST_MV_DIV:
            begin
                iter_ctl.start = 1'b1;
                iter_ctl.mode  = ITER_DIV;
            end
            default:
            begin
                sphere.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_c_reg[0]  <= '0;
            acc_c_reg[1]  <= '0;
            acc_c_reg[2]  <= '0;
            acc_r_reg     <= '0;
            axis_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // A new result replaces the one being taken in the same cycle.
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (merged.ready && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CHECK:
                begin
                    axis_reg <= '0;
                    if (!identical && empty_acc)
                    begin
                        acc_c_reg[0] <= in_c_reg[0];
                        acc_c_reg[1] <= in_c_reg[1];
                        acc_c_reg[2] <= in_c_reg[2];
                        acc_r_reg    <= in_r_reg;
                    end
                end
                ST_SQ_ACC:
                begin
                    axis_reg <= axis_reg + 2'd1;
                end
                ST_CMP:
                begin
                    if (contained && (acc_r_reg <= in_r_reg))
                    begin
                        acc_c_reg[0] <= in_c_reg[0];
                        acc_c_reg[1] <= in_c_reg[1];
                        acc_c_reg[2] <= in_c_reg[2];
                        acc_r_reg    <= in_r_reg;
                    end
                end
                ST_KCALC:
                begin
                    axis_reg <= '0;
                end
                ST_MV_WAIT:
                begin
                    if (iter_done)
                    begin
                        acc_c_reg[axis_reg] <= moved_clamped;
                        axis_reg            <= axis_reg + 2'd1;
                    end
                end
                ST_FIN:
                begin
                    if (rtrue_reg > OpW'({RadW{1'b1}}))
                    begin
                        acc_r_reg <= {RadW{1'b1}};
                    end
                    else
                    begin
                        acc_r_reg <= rtrue_reg[RadW-1:0];
                    end
                end
                default:
                begin
                    axis_reg <= axis_reg;
                end
            endcase
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_c_reg[0] <= sphere.in_center_x;
            in_c_reg[1] <= sphere.in_center_y;
            in_c_reg[2] <= sphere.in_center_z;
            in_r_reg    <= sphere.in_radius;
        end
        case (state_reg)
            ST_CHECK:
            begin
                sum_reg <= '0;
                sat_reg <= 1'b0;
                if (identical)
                begin
                    case_reg <= CASE_IDENT;
                end
                else
                begin
                    case_reg <= CASE_TAKEN;
                end
            end
            ST_SQ_ACC:
            begin
                if (axis_reg == 2'd3)
                begin
                    diffsq_reg <= prod[61:0];
                end
                else
                begin
                    sum_reg <= sum_reg + {1'b0, prod[64:0]};
                end
            end
            ST_CMP:
            begin
                if (acc_r_reg <= in_r_reg)
                begin
                    case_reg <= CASE_TAKEN;
                end
                else
                begin
                    case_reg <= CASE_KEPT;
                end
            end
            ST_KCALC:
            begin
                d_reg     <= d_fix;
                rtrue_reg <= rtrue;
                k_reg     <= (rtrue >= OpW'(acc_r_reg)) ? (rtrue - OpW'(acc_r_reg)) : '0;
                case_reg  <= CASE_ENLARGE;
            end
            ST_MV_MUL:
            begin
                neg_reg <= delta[32];
            end
            ST_MV_WAIT:
            begin
                if (iter_done && moved_sat)
                begin
                    sat_reg <= 1'b1;
                end
            end
            ST_FIN:
            begin
                if (rtrue_reg > OpW'({RadW{1'b1}}))
                begin
                    sat_reg <= 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_cx_reg   <= acc_c_reg[0];
                    out_cy_reg   <= acc_c_reg[1];
                    out_cz_reg   <= acc_c_reg[2];
                    out_r_reg    <= acc_r_reg;
                    out_case_reg <= case_reg;
                    out_sat_reg  <= sat_reg;
                end
            end
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end

    assign merged.valid        = out_valid_reg;
    assign merged.out_center_x = out_cx_reg;
    assign merged.out_center_y = out_cy_reg;
    assign merged.out_center_z = out_cz_reg;
    assign merged.out_radius   = out_r_reg;
    assign merged.merge_case   = out_case_reg;
    assign merged.saturated    = out_sat_reg;
endmodule

// ===== rtl/bsm_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on bsm_pkg for operand widths.
module bsm_mul (
    input  logic                      clk,
    input  logic [bsm_pkg::OpW-1:0]   a,
    input  logic [bsm_pkg::OpW-1:0]   b,
    output logic [bsm_pkg::ProdW-1:0] p
);
    import bsm_pkg::*;

    logic [ProdW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule

// ===== rtl/bsm_iter.sv =====
// Shared iterative unit: digit-by-digit square root or restoring division,
// one result bit per cycle through a single subtract-and-compare. Uses bsm_pkg.
module bsm_iter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bsm_pkg::bsm_iter_ctl_t    ctl,
    input  logic [bsm_pkg::SumW-1:0]  radicand,
    input  logic [66:0]               dividend,
    input  logic [bsm_pkg::OpW-1:0]   divisor,
    output logic                      done,
    output logic [bsm_pkg::OpW-1:0]   result
);
    import bsm_pkg::*;

    logic [36:0]         rem_reg;
    logic [67:0]         src_reg;
    logic [OpW-1:0]      res_reg;
    logic [OpW-1:0]      div_reg;
    logic [IterCntW-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    bsm_iter_mode_t      mode_reg;

    logic [36:0] shifted;
    logic [36:0] sub_val;
    logic [36:0] diff_val;
    logic        ge;

    always_comb
    begin
        if (mode_reg == ITER_SQRT)
        begin
            shifted = {rem_reg[34:0], src_reg[67:66]};
            sub_val = {1'b0, res_reg, 2'b01};
        end
        else
        begin
            shifted = {rem_reg[35:0], src_reg[67]};
            sub_val = {3'b000, div_reg};
        end
        ge       = (shifted >= sub_val);
        diff_val = shifted - sub_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= ITER_SQRT;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == IterCntW'(1));
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= IterCntW'(IterN);
                mode_reg <= ctl.mode;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - IterCntW'(1);
                if (cnt_reg == IterCntW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            res_reg <= '0;
            div_reg <= divisor;
            if (ctl.mode == ITER_SQRT)
            begin
                rem_reg <= '0;
                src_reg <= {2'b00, radicand};
            end
            else
            begin
                // The quotient fits in 34 bits, so the top part is already below the divisor.
                rem_reg <= {4'b0000, dividend[66:34]};
                src_reg <= {dividend[33:0], 34'd0};
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff_val : shifted;
            src_reg <= (mode_reg == ITER_SQRT) ? {src_reg[65:0], 2'b00}
                                               : {src_reg[66:0], 1'b0};
            res_reg <= {res_reg[OpW-2:0], ge};
        end
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

// ===== test/tb_bounding_sphere_merge_core.sv =====
// Self-checking testbench for bounding_sphere_merge_core.
// Depends on bsm_pkg, the sphere channel interfaces and the block itself.
// A directed table runs first, then random spheres under four idling phases.
`timescale 1ns / 1ps

module tb_bounding_sphere_merge_core;
    import bsm_pkg::*;

    localparam int  NumRandom = 1730;
    localparam int  CycleLimit = 2000000;
    localparam int  DrainCycles = 400;
    localparam longint CoordHi = 64'sd2147483647;
    localparam longint CoordLo = -64'sd2147483648;
    localparam longint RadiusHi = 64'sd2147483647;

    typedef struct {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
        logic        [RadW-1:0]   r;
    } sphere_t;

    typedef struct {
        sphere_t    s;
        logic [1:0] mcase;
        logic       sat;
    } merged_t;

    // One row of the directed table; has_exp marks a hand-written answer.
    typedef struct {
        sphere_t s;
        logic    has_exp;
        merged_t exp_res;
    } row_t;

    logic clk;
    logic rst_n;
    int   cycles;
    int   errors;
    int   results_seen;
    int   enlarge_seen;
    int   sat_seen;
    int   sender_idle_pct;
    int   receiver_stall_pct;

    bsm_sphere_if sphere ();
    bsm_merged_if merged ();

    bounding_sphere_merge_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sphere (sphere.sink),
        .merged (merged.source)
    );

    // The predictor's copy of the running sphere.
    sphere_t hull;

    // Merged spheres the block still owes, oldest first.
    merged_t pending_merges[$];

    // Directed table; answers are written out only where they are obvious.
    row_t directed[$];

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, pending_merges.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic longint clamp_coord(input longint v, inout logic sat);
        if (v > CoordHi)
        begin
            sat = 1'b1;
            return CoordHi;
        end
        if (v < CoordLo)
        begin
            sat = 1'b1;
            return CoordLo;
        end
        return v;
    endfunction

    // Moves one center axis toward the incoming center by |delta| * k / d.
    function automatic longint shift_axis(input longint c1, input longint c2,
                                          input longint k, input longint d,
                                          inout logic sat);
        longint       delta;
        logic [127:0] prod;
        logic [127:0] quot;
        longint       step;
        delta = c2 - c1;
        prod  = 128'(delta < 0 ? -delta : delta) * 128'(k);
        quot  = prod / 128'(d);
        step  = longint'(quot[63:0]);
        return clamp_coord(delta < 0 ? c1 - step : c1 + step, sat);
    endfunction

    // Folds one incoming sphere into the running sphere and returns the result.
    function automatic merged_t fold_sphere(input sphere_t inc);
        merged_t      res;
        longint       dv[3];
        logic [127:0] dist2;
        logic [127:0] cand_sq;
        logic [127:0] gap_sq;
        longint       r1;
        longint       r2;
        longint       gap;
        longint       root;
        longint       cand;
        longint       rtrue;
        longint       k;
        logic         sat;
        sat = 1'b0;
        r1  = longint'(hull.r);
        r2  = longint'(inc.r);
        if (inc == hull)
            res.mcase = CASE_IDENT;
        else if (hull.x == 0 && hull.y == 0 && hull.z == 0 && hull.r == 0)
        begin
            hull = inc;
            res.mcase = CASE_TAKEN;
        end
        else
        begin
            dv[0] = longint'(inc.x) - longint'(hull.x);
            dv[1] = longint'(inc.y) - longint'(hull.y);
            dv[2] = longint'(inc.z) - longint'(hull.z);
            dist2 = '0;
            for (int a = 0; a < 3; a++)
                dist2 += 128'(dv[a] < 0 ? -dv[a] : dv[a]) * 128'(dv[a] < 0 ? -dv[a] : dv[a]);
            gap    = r1 > r2 ? r1 - r2 : r2 - r1;
            gap_sq = 128'(gap) * 128'(gap);
            if (dist2 <= gap_sq)
            begin
                // One sphere holds the other; the larger one survives.
                if (r1 <= r2)
                begin
                    hull = inc;
                    res.mcase = CASE_TAKEN;
                end
                else
                    res.mcase = CASE_KEPT;
            end
            else
            begin
                root = 0;
                for (int b = 33; b >= 0; b--)
                begin
                    cand    = root | (64'sd1 << b);
                    cand_sq = 128'(cand) * 128'(cand);
                    if (cand_sq <= dist2)
                        root = cand;
                end
                if (root == 0)
                    root = 1;
                rtrue = (root + r1 + r2) >>> 1;
                k     = rtrue >= r1 ? rtrue - r1 : 0;
                // The center moves with the unclamped radius.
                hull.x = CoordW'(shift_axis(longint'(hull.x), longint'(inc.x), k, root, sat));
                hull.y = CoordW'(shift_axis(longint'(hull.y), longint'(inc.y), k, root, sat));
                hull.z = CoordW'(shift_axis(longint'(hull.z), longint'(inc.z), k, root, sat));
                if (rtrue > RadiusHi)
                begin
                    rtrue = RadiusHi;
                    sat   = 1'b1;
                end
                hull.r = RadW'(rtrue);
                res.mcase = CASE_ENLARGE;
            end
        end
        res.s   = hull;
        res.sat = sat;
        return res;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("Mismatch at cycle %0d, result %0d: %s got %0d, expected %0d",
                 cycles, results_seen, what, got, want);
        errors++;
    endtask

    // Hands one sphere to the block, idling first as the current phase asks.
    task automatic send_sphere(input sphere_t s);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sphere.valid <= 1'b0;
            @(posedge clk);
        end
        sphere.valid       <= 1'b1;
        sphere.in_center_x <= s.x;
        sphere.in_center_y <= s.y;
        sphere.in_center_z <= s.z;
        sphere.in_radius   <= s.r;
        do
            @(posedge clk);
        while (!sphere.ready);
    endtask

    function automatic sphere_t make_sphere(input longint x, input longint y,
                                            input longint z, input longint r);
        sphere_t s;
        s.x = CoordW'(x);
        s.y = CoordW'(y);
        s.z = CoordW'(z);
        s.r = RadW'(r);
        return s;
    endfunction

    function automatic row_t make_row(input sphere_t s, input logic has_exp,
                                      input sphere_t es, input logic [1:0] mc);
        row_t row;
        row.s               = s;
        row.has_exp         = has_exp;
        row.exp_res.s       = es;
        row.exp_res.mcase   = mc;
        row.exp_res.sat     = 1'b0;
        return row;
    endfunction

    // Random sphere: mostly small, with repeats and spheres near the running sphere
    // so that every handling case stays reachable, and some full-range noise mixed in.
    function automatic sphere_t random_sphere(input sphere_t last_in);
        sphere_t s;
        int      pick;
        pick = $urandom_range(99);
        if (pick < 8)
            s = last_in;
        else if (pick < 16)
            s = hull;
        else if (pick < 30)
        begin
            s.x = hull.x + CoordW'($signed($urandom_range(64)) - 32);
            s.y = hull.y + CoordW'($signed($urandom_range(64)) - 32);
            s.z = hull.z + CoordW'($signed($urandom_range(64)) - 32);
            s.r = pick < 22 ? RadW'($urandom_range(16)) : hull.r + RadW'($urandom_range(200));
        end
        else if (pick < 45)
        begin
            s.x = $urandom;
            s.y = $urandom;
            s.z = $urandom;
            s.r = RadW'($urandom);
        end
        else
        begin
            s.x = CoordW'($signed($urandom_range(1 << 20)) - (1 << 19));
            s.y = CoordW'($signed($urandom_range(1 << 20)) - (1 << 19));
            s.z = CoordW'($signed($urandom_range(1 << 20)) - (1 << 19));
            s.r = RadW'($urandom_range(1 << 18));
        end
        return s;
    endfunction

    // Monitor: every transfer on the merged channel is checked against the
    // oldest outstanding prediction, then ready is redrawn for the next edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            merged.ready <= 1'b0;
        else
        begin
            if (merged.valid && merged.ready)
            begin
                merged_t want;
                results_seen++;
                if (pending_merges.size() == 0)
                    report("unexpected result, queue depth", 1, 0);
                else
                begin
                    want = pending_merges.pop_front();
                    if (merged.out_center_x !== want.s.x)
                        report("out_center_x", merged.out_center_x, want.s.x);
                    if (merged.out_center_y !== want.s.y)
                        report("out_center_y", merged.out_center_y, want.s.y);
                    if (merged.out_center_z !== want.s.z)
                        report("out_center_z", merged.out_center_z, want.s.z);
                    if (merged.out_radius !== want.s.r)
                        report("out_radius", merged.out_radius, want.s.r);
                    if (merged.merge_case !== want.mcase)
                        report("merge_case", merged.merge_case, want.mcase);
                    if (merged.saturated !== want.sat)
                        report("saturated", merged.saturated, want.sat);
                    if (want.mcase == CASE_ENLARGE)
                        enlarge_seen++;
                    if (want.sat)
                        sat_seen++;
                end
            end
            merged.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial
    begin
        sphere_t last_in;
        merged_t want;
        int      phase;
        sphere_t zero_s;

        cycles             = 0;
        errors             = 0;
        results_seen       = 0;
        enlarge_seen       = 0;
        sat_seen           = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        sphere.valid       = 1'b0;
        sphere.in_center_x = '0;
        sphere.in_center_y = '0;
        sphere.in_center_z = '0;
        sphere.in_radius   = '0;
        hull               = make_sphere(0, 0, 0, 0);
        zero_s             = hull;
        rst_n              = 1'b0;

        // Directed rows. The first six follow straight from the rules:
        // an empty sphere after reset matches the sentinel and is ignored,
        // the first real sphere is taken, a repeat is ignored, a smaller
        // concentric sphere is kept, a larger concentric one is taken and an
        // empty sphere inside it is kept.
        directed.push_back(make_row(zero_s, 1'b1, zero_s, CASE_IDENT));
        directed.push_back(make_row(make_sphere(100, 200, 300, 50), 1'b1,
                                    make_sphere(100, 200, 300, 50), CASE_TAKEN));
        directed.push_back(make_row(make_sphere(100, 200, 300, 50), 1'b1,
                                    make_sphere(100, 200, 300, 50), CASE_IDENT));
        directed.push_back(make_row(make_sphere(100, 200, 300, 10), 1'b1,
                                    make_sphere(100, 200, 300, 50), CASE_KEPT));
        directed.push_back(make_row(make_sphere(100, 200, 300, 1000), 1'b1,
                                    make_sphere(100, 200, 300, 1000), CASE_TAKEN));
        directed.push_back(make_row(zero_s, 1'b1,
                                    make_sphere(100, 200, 300, 1000), CASE_KEPT));
        // Enlarging merges, the field extremes and radius saturation.
        directed.push_back(make_row(make_sphere(5000, 200, 300, 10), 1'b0, zero_s,
                                    CASE_IDENT));
        directed.push_back(make_row(make_sphere(-1, -1, -1, 1), 1'b0, zero_s, CASE_IDENT));
        directed.push_back(make_row(make_sphere(CoordHi, CoordHi, CoordHi, 0), 1'b0, zero_s,
                                    CASE_IDENT));
        directed.push_back(make_row(make_sphere(CoordLo, CoordLo, CoordLo, RadiusHi),
                                    1'b0, zero_s, CASE_IDENT));
        directed.push_back(make_row(make_sphere(CoordHi, CoordLo, CoordHi, RadiusHi),
                                    1'b0, zero_s, CASE_IDENT));
        directed.push_back(make_row(make_sphere(CoordLo, CoordHi, CoordLo, RadiusHi),
                                    1'b0, zero_s, CASE_IDENT));
        directed.push_back(make_row(zero_s, 1'b0, zero_s, CASE_IDENT));
        directed.push_back(make_row(make_sphere(1, 0, -1, 1), 1'b0, zero_s, CASE_IDENT));
        directed.push_back(make_row(make_sphere(0, 0, 0, RadiusHi), 1'b0, zero_s,
                                    CASE_IDENT));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_sphere(directed[i].s);
            want = fold_sphere(directed[i].s);
            pending_merges.push_back(directed[i].has_exp ? directed[i].exp_res : want);
            last_in = directed[i].s;
        end

        // Random part in four idling phases: none, sender idle, receiver
        // stalling, then both.
        for (int n = 0; n < NumRandom; n++)
        begin
            sphere_t s;
            phase = n * 4 / NumRandom;
            sender_idle_pct    = (phase == 1) ? 72 : (phase == 3) ? 12 : 0;
            receiver_stall_pct = (phase == 2) ? 72 : (phase == 3) ? 12 : 0;
            s = random_sphere(last_in);
            send_sphere(s);
            pending_merges.push_back(fold_sphere(s));
            last_in = s;
        end
        sphere.valid <= 1'b0;

        while (pending_merges.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Checked %0d merged spheres, %0d of them enlarging merges and %0d saturated,",
                 results_seen, enlarge_seen, sat_seen);
        $display("over %0d clock cycles with sender and receiver idling in turn.", cycles);
        if (errors == 0 && pending_merges.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bsm_pkg.sv
rtl/bsm_sphere_if.sv
rtl/bsm_mul.sv
rtl/bsm_iter.sv
rtl/bounding_sphere_merge_core.sv
test/tb_bounding_sphere_merge_core.sv
